// ----- hdl/i2cw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cw_pkg
// Shared types and constants of the three-byte write master.
// ----------------------------------------------------------------------------
package i2cw_pkg;

    localparam int          QUEUE_DEPTH  = 2;
    localparam logic [6:0]  ADDR_RESET   = 7'd62;

    localparam logic [6:0]  STEP_IDLE    = 7'd0;
    localparam logic [6:0]  STEP_FIRST   = 7'd1;
    localparam logic [6:0]  START_LAST   = 7'd4;
    localparam logic [6:0]  BYTES_LAST   = 7'd85;
    localparam logic [6:0]  STOP_SCL_UP  = 7'd86;
    localparam logic [6:0]  STOP_SDA_LOW = 7'd87;
    localparam logic [6:0]  STOP_SDA_UP  = 7'd88;
    localparam logic [6:0]  FRAME_LAST   = 7'd89;

    localparam logic [1:0]  START_SCL_UP  = 2'd1;
    localparam logic [1:0]  START_SDA_LOW = 2'd2;
    localparam logic [1:0]  START_SDA_UP  = 2'd3;

    localparam logic [4:0]  SLOT_ACK_SDA  = 5'd24;
    localparam logic [4:0]  SLOT_ACK_RISE = 5'd25;
    localparam logic [4:0]  SLOT_LAST     = 5'd26;

    typedef struct packed {
        logic        is_start;
        logic [15:0] code;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic busy;
        logic sda;
        logic scl;
    } t_pins;

endpackage
`default_nettype wire

// ----- hdl/i2cw_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cw_front
// Input stage: accepts items, classifies them as start or tick and holds one.
// ----------------------------------------------------------------------------
module i2cw_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [15:0]   s_axis_tdata,   // command_code
    input  wire logic          s_axis_tuser,   // kind
    output logic               o_cmd_valid,
    output i2cw_pkg::t_cmd     o_cmd,
    input  wire logic          i_cmd_ready
);
    import i2cw_pkg::*;

    logic r_valid;
    t_cmd r_cmd;

    assign s_axis_tready = !r_valid || i_cmd_ready;
    assign o_cmd_valid   = r_valid;
    assign o_cmd         = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd.is_start <= s_axis_tuser;
            r_cmd.code     <= s_axis_tdata;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/i2cw_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cw_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module i2cw_queue #(
    parameter int DEPTH = i2cw_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    input  wire i2cw_pkg::t_cmd i_push,
    output logic               o_pop_valid,
    output i2cw_pkg::t_cmd     o_pop,
    input  wire logic          i_pop_ready
);
    import i2cw_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_cnt != CNT_FULL);
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop        = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr] <= i_push;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/i2cw_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cw_back
// Frame sequencer: runs one pin step per tick and registers each result item.
// ----------------------------------------------------------------------------
module i2cw_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [6:0]    i_device_address,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_ready,
    input  wire i2cw_pkg::t_cmd i_cmd,
    output logic               o_out_valid,
    output i2cw_pkg::t_pins    o_out,
    input  wire logic          i_out_ready
);
    import i2cw_pkg::*;

    localparam logic [1:0] PH_SDA  = 2'd0;
    localparam logic [1:0] PH_RISE = 2'd1;
    localparam logic [1:0] PH_FALL = 2'd2;

    logic [6:0]  r_step, n_step;
    logic [4:0]  r_slot, n_slot;
    logic [1:0]  r_ph,   n_ph;
    logic [7:0]  r_shift, n_shift;
    logic [1:0]  r_bidx, n_bidx;
    logic [15:0] r_code, n_code;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        n_done;
    logic        r_out_valid;
    t_pins       r_out;
    logic        take;

    assign o_cmd_ready = !r_out_valid || i_out_ready;
    assign take        = i_cmd_valid && o_cmd_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_step  = r_step;
        n_slot  = r_slot;
        n_ph    = r_ph;
        n_shift = r_shift;
        n_bidx  = r_bidx;
        n_code  = r_code;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_done  = 1'b0;
        if (i_cmd.is_start) begin
            if (r_step == STEP_IDLE) begin
                n_code  = i_cmd.code;
                n_step  = STEP_FIRST;
                n_slot  = '0;
                n_ph    = PH_SDA;
                n_bidx  = '0;
                n_shift = {i_device_address, 1'b0};
            end
        end else if (r_step != STEP_IDLE) begin
            if (r_step <= START_LAST) begin
                unique case (r_step[1:0])
                    START_SCL_UP:  n_scl = 1'b0;
                    START_SDA_LOW: n_sda = 1'b0;
                    START_SDA_UP:  n_sda = 1'b1;
                    default:       n_scl = 1'b1;
                endcase
            end else if (r_step <= BYTES_LAST) begin
                n_slot = (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
                if (r_slot < SLOT_ACK_SDA) begin
                    unique case (r_ph)
                        PH_SDA: begin
                            n_sda = !r_shift[7];
                            n_ph  = PH_RISE;
                        end
                        PH_RISE: begin
                            n_scl = 1'b0;
                            n_ph  = PH_FALL;
                        end
                        default: begin
                            n_scl   = 1'b1;
                            n_shift = {r_shift[6:0], 1'b0};
                            n_ph    = PH_SDA;
                        end
                    endcase
                end else if (r_slot == SLOT_ACK_SDA) begin
                    n_sda = 1'b0;
                end else if (r_slot == SLOT_ACK_RISE) begin
                    n_scl = 1'b0;
                end else begin
                    n_scl   = 1'b1;
                    n_bidx  = r_bidx + 1'b1;
                    n_shift = (r_bidx == 2'd0) ? r_code[15:8] : r_code[7:0];
                end
            end else begin
                unique case (r_step)
                    STOP_SCL_UP:  n_scl = 1'b0;
                    STOP_SDA_LOW: n_sda = 1'b1;
                    STOP_SDA_UP:  n_sda = 1'b0;
                    default: begin
                        n_scl  = 1'b1;
                        n_done = 1'b1;
                    end
                endcase
            end
            n_step = (n_done || r_step >= FRAME_LAST) ? STEP_IDLE : r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_IDLE;
            r_slot      <= '0;
            r_ph        <= PH_SDA;
            r_shift     <= '0;
            r_bidx      <= '0;
            r_code      <= '0;
            r_scl       <= 1'b0;
            r_sda       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_step      <= n_step;
                r_slot      <= n_slot;
                r_ph        <= n_ph;
                r_shift     <= n_shift;
                r_bidx      <= n_bidx;
                r_code      <= n_code;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (take) begin
            r_out.scl  <= n_scl;
            r_out.sda  <= n_sda;
            r_out.busy <= (n_step != STEP_IDLE);
            r_out.done <= n_done;
        end
    end

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= FRAME_LAST)
        else $error("step counter out of frame");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done) |-> (!r_out.busy && r_out.scl && !r_out.sda))
        else $error("frame end without idle bus state");

    a_start_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_cmd.is_start && r_step == STEP_IDLE) |=> (r_step == STEP_FIRST))
        else $error("start item not latched");

endmodule
`default_nettype wire

// ----- hdl/i2c_three_byte_write_master.sv -----
// Accepted items load the input register, then pass the queue and the output register.
// Throughput: one item per cycle while m_axis_tready does not stall the output;
// so too the pin sequencer, which takes one tick item per clock.
// A frame takes one start item and 89 tick items.
// Reset (synchronous, active low) empties the queue, idles the sequencer,
// releases both pins and sets device_address to 62.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_three_byte_write_master
// Write-only I2C master sending address, high and low code byte per frame.
// ----------------------------------------------------------------------------
module i2c_three_byte_write_master #(
    parameter int QUEUE_DEPTH = i2cw_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // command_code
    input  wire logic        s_axis_tuser,   // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [7:0]  m_axis_tdata,   // scl_pull_low, sda_pull_low, busy_res, zeros
    output logic             m_axis_tlast    // frame_done
);
    import i2cw_pkg::*;

    logic [6:0] r_device_address;
    logic       f_valid;
    logic       f_ready;
    t_cmd       f_cmd;
    logic       q_valid;
    logic       q_ready;
    t_cmd       q_cmd;
    t_pins      out_pins;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {25'd0, r_device_address} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= ADDR_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            r_device_address <= pwdata[6:0];
        end
    end

    i2cw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd_valid   (f_valid),
        .o_cmd         (f_cmd),
        .i_cmd_ready   (f_ready)
    );

    i2cw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push       (f_cmd),
        .o_pop_valid  (q_valid),
        .o_pop        (q_cmd),
        .i_pop_ready  (q_ready)
    );

    i2cw_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_device_address (r_device_address),
        .i_cmd_valid      (q_valid),
        .o_cmd_ready      (q_ready),
        .i_cmd            (q_cmd),
        .o_out_valid      (m_axis_tvalid),
        .o_out            (out_pins),
        .i_out_ready      (m_axis_tready)
    );

    assign m_axis_tdata = {5'd0, out_pins.busy, out_pins.sda, out_pins.scl};
    assign m_axis_tlast = out_pins.done;

endmodule
`default_nettype wire
